### sv/ctwvt_pkg.sv
// Package for the clip-to-window viewport transform.
// Holds register indexes, widths and shared fixed-point helpers; no dependencies.
package ctwvt_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned DepthW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned RecipW = 34;  // quotient bits for 2^32 / v

  typedef enum logic [CfgIdxW-1:0] {
    RegScaleX  = 3'd0,
    RegScaleY  = 3'd1,
    RegOriginX = 3'd2,
    RegOriginY = 3'd3,
    RegDepthF  = 3'd4,
    RegDepthB  = 3'd5
  } cfg_reg_e;

  // 16.16 multiply: 64-bit product shifted right 16, low 32 bits
  function automatic logic [DataW-1:0] fx_mul(input logic signed [DataW-1:0] a,
                                               input logic signed [DataW-1:0] b);
    logic signed [2*DataW-1:0] p;
    begin
      p = a * b;
      fx_mul = p[DataW+15:16];
    end
  endfunction

  // clamp c to -w..w, lower bound first
  function automatic logic [DataW-1:0] clamp_w(input logic signed [DataW-1:0] c,
                                                input logic signed [DataW-1:0] w);
    logic signed [DataW-1:0] nw;
    logic signed [DataW-1:0] r;
    begin
      nw = -w;
      r = c;
      if (r < nw) r = nw;
      if (r > w) r = w;
      clamp_w = r;
    end
  endfunction

endpackage

### sv/ctwvt_recip.sv
// Pipelined restoring reciprocal: truncated 2^32 / v, low 32 bits, 0 for v = 0.
// One quotient bit per stage, sideband travels alongside. Uses ctwvt_pkg.
module ctwvt_recip
  import ctwvt_pkg::*;
#(
  parameter int unsigned SideW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [DataW-1:0]  div_i,
  input  logic [SideW-1:0]  side_i,
  output logic              valid_o,
  output logic [DataW-1:0]  recip_o,
  output logic [SideW-1:0]  side_o
);

  localparam int unsigned NumSt = RecipW;
  localparam int unsigned RemW = DataW + 1;

  logic [NumSt:0]            vld_q;
  logic [RemW-1:0]           rem_q  [NumSt+1];
  logic [RecipW-1:0]         quo_q  [NumSt+1];
  logic [DataW-1:0]          mag_q  [NumSt+1];
  logic                      neg_q  [NumSt+1];
  logic [SideW-1:0]          side_q [NumSt+1];

  // stage 0: take magnitude and sign of the divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else         vld_q[0] <= valid_i;
  end
  always_ff @(posedge clk_i) begin
    neg_q[0]  <= div_i[DataW-1];
    mag_q[0]  <= div_i[DataW-1] ? (~div_i + 1'b1) : div_i;
    rem_q[0]  <= '0;
    quo_q[0]  <= '0;
    side_q[0] <= side_i;
  end

  // one dividend bit per stage; dividend is 2^32 (bit 32 only)
  for (genvar s = 0; s < NumSt; s++) begin : g_st
    localparam int unsigned BitPos = NumSt - 1 - s;
    logic [RemW:0]  trial;
    logic           dbit;
    assign dbit  = (BitPos == DataW);
    assign trial = {rem_q[s], dbit} - {2'b00, mag_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[s+1] <= 1'b0;
      else         vld_q[s+1] <= vld_q[s];
    end
    always_ff @(posedge clk_i) begin
      if (!trial[RemW]) begin
        rem_q[s+1] <= trial[RemW-1:0];
        quo_q[s+1] <= {quo_q[s][RecipW-2:0], 1'b1};
      end else begin
        rem_q[s+1] <= {rem_q[s][RemW-2:0], dbit};
        quo_q[s+1] <= {quo_q[s][RecipW-2:0], 1'b0};
      end
      mag_q[s+1]  <= mag_q[s];
      neg_q[s+1]  <= neg_q[s];
      side_q[s+1] <= side_q[s];
    end
  end

  // apply sign; zero divisor gives 0
  always_comb begin
    logic [DataW-1:0] q;
    q = quo_q[NumSt][DataW-1:0];
    if (mag_q[NumSt] == '0) recip_o = '0;
    else if (neg_q[NumSt])  recip_o = ~q + 1'b1;
    else                    recip_o = q;
  end
  assign valid_o = vld_q[NumSt];
  assign side_o  = side_q[NumSt];

endmodule

### sv/clip_to_window_viewport_transform_top.sv
// Clip-to-window viewport transform: clamp, pipelined reciprocal, viewport scale.
// done_o follows the edge that accepts start through the clamp stage, the 35-stage
// reciprocal, two product stages and the output stage.
// Throughput one item per cycle.
// busy is always low: an item may start every cycle and the result cannot stall.
// Reset clears the valid pipeline and all viewport registers to 0.
// Depends on ctwvt_pkg and ctwvt_recip.
module clip_to_window_viewport_transform_top
  import ctwvt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [DataW-1:0]         cfg_data_i,
  input  logic signed [DataW-1:0]  clip_x_i,
  input  logic signed [DataW-1:0]  clip_y_i,
  input  logic signed [DataW-1:0]  clip_z_i,
  input  logic signed [DataW-1:0]  clip_w_i,
  output logic                     done_o,
  output logic signed [DataW-1:0]  win_x_o,
  output logic signed [DataW-1:0]  win_y_o,
  output logic [DepthW-1:0]        win_depth_o,
  output logic signed [DataW-1:0]  inv_w_o
);

  localparam int unsigned SideW = 3*DataW + 1;

  logic [DataW-1:0] scale_x_q, scale_y_q, org_x_q, org_y_q, dep_f_q, dep_b_q;

  // hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_x_q <= '0; scale_y_q <= '0; org_x_q <= '0;
      org_y_q <= '0; dep_f_q <= '0; dep_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegScaleX:  scale_x_q <= cfg_data_i;
        RegScaleY:  scale_y_q <= cfg_data_i;
        RegOriginX: org_x_q   <= cfg_data_i;
        RegOriginY: org_y_q   <= cfg_data_i;
        RegDepthF:  dep_f_q   <= cfg_data_i;
        RegDepthB:  dep_b_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage A: clamp, pick branch, pre-shift
  logic             va_q;
  logic [DataW-1:0] ax_q, ay_q, az_q, adiv_q;
  logic             abig_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= start;
  end
  always_ff @(posedge clk_i) begin
    logic [DataW-1:0] cx, cy, cz;
    logic signed [DataW-1:0] hi;
    logic big;
    cx = clamp_w(clip_x_i, clip_w_i);
    cy = clamp_w(clip_y_i, clip_w_i);
    cz = clamp_w(clip_z_i, clip_w_i);
    hi = clip_w_i >>> 24;
    big = (hi != '0) && (hi != '1);
    abig_q <= big;
    ax_q   <= big ? DataW'($signed(cx) >>> 8) : cx;
    ay_q   <= big ? DataW'($signed(cy) >>> 8) : cy;
    az_q   <= big ? DataW'($signed(cz) >>> 8) : cz;
    adiv_q <= big ? DataW'(clip_w_i >>> 8) : clip_w_i;
  end

  // reciprocal pipeline carries x, y, z and the branch flag
  logic             vr;
  logic [DataW-1:0] r;
  logic [SideW-1:0] side_r;
  ctwvt_recip #(.SideW(SideW)) u_recip (
    .clk_i, .rst_ni,
    .valid_i (va_q),
    .div_i   (adiv_q),
    .side_i  ({abig_q, ax_q, ay_q, az_q}),
    .valid_o (vr),
    .recip_o (r),
    .side_o  (side_r)
  );

  logic             rbig;
  logic [DataW-1:0] rx, ry, rz;
  assign {rbig, rx, ry, rz} = side_r;

  // stage B: first products
  logic             vb_q, bbig_q;
  logic [DataW-1:0] bx_q, by_q, bz_q, bzz_q, binv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= vr;
  end
  always_ff @(posedge clk_i) begin
    bbig_q <= rbig;
    bx_q   <= fx_mul(rx, r);
    by_q   <= fx_mul(ry, r);
    bz_q   <= rbig ? fx_mul(dep_f_q, r) : fx_mul(rz, r);
    bzz_q  <= rz;
    binv_q <= rbig ? (r << 4) : (r << 12);
  end

  // stage C: second products plus offsets
  logic             vc_q, cbig_q;
  logic [DataW-1:0] cx_q, cy_q, cd_q, cinv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    cbig_q <= bbig_q;
    cx_q   <= fx_mul(bx_q, scale_x_q) + org_x_q;
    cy_q   <= fx_mul(by_q, scale_y_q) + org_y_q;
    cd_q   <= (bbig_q ? fx_mul(bzz_q, bz_q) : fx_mul(bz_q, dep_f_q)) + dep_b_q;
    cinv_q <= binv_q;
  end

  // stage D: rounding and depth clamp into output register
  logic vd_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else         vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    logic [DataW-1:0] rx2, ry2;
    rx2 = (cx_q + 32'h800) & ~32'hfff;
    ry2 = (cy_q + 32'h800) & ~32'hfff;
    win_x_o <= cbig_q ? cx_q : rx2;
    win_y_o <= cbig_q ? cy_q : ry2;
    if ($signed(cd_q) < 0)                 win_depth_o <= '0;
    else if ($signed(cd_q) > 32'sh0000ffff) win_depth_o <= '1;
    else                                    win_depth_o <= cd_q[DepthW-1:0];
    inv_w_o <= cinv_q;
  end
  assign done_o = vd_q;

endmodule

### bench/tb_top.sv
// Self-checking bench for clip_to_window_viewport_transform_top.
// Drives vertices through a directed table and random phases, predicts each result
// in-bench or takes it from the table, and checks every done_o strobe; depends on ctwvt_pkg and the RTL.
module tb_top;
  import ctwvt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainWait  = 60;

  typedef struct packed {
    logic [DataW-1:0]  win_x;
    logic [DataW-1:0]  win_y;
    logic [DepthW-1:0] win_depth;
    logic [DataW-1:0]  inv_w;
  } vtx_result_t;

  typedef struct {
    logic [DataW-1:0] x;
    logic [DataW-1:0] y;
    logic [DataW-1:0] z;
    logic [DataW-1:0] w;
    bit               typed;
    vtx_result_t      res;
  } vtx_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_idx_i = RegScaleX;
  logic [DataW-1:0] cfg_data_i = '0;
  logic signed [DataW-1:0] clip_x_i = '0, clip_y_i = '0, clip_z_i = '0, clip_w_i = '0;
  logic done_o;
  logic signed [DataW-1:0] win_x_o, win_y_o, inv_w_o;
  logic [DepthW-1:0] win_depth_o;

  // viewport register mirror
  logic [DataW-1:0] vp_regs [6];
  vtx_result_t pending_vtx [$];
  vtx_result_t typed_vtx [$];
  bit          typed_flag [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;

  clip_to_window_viewport_transform_top DUT (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .clip_x_i, .clip_y_i, .clip_z_i, .clip_w_i,
    .done_o, .win_x_o, .win_y_o, .win_depth_o, .inv_w_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // 16.16 product, wrapped to 32 bits
  function automatic logic [DataW-1:0] fixmul(input logic [DataW-1:0] a, b);
    logic signed [63:0] p;
    p = $signed(a) * $signed(b);
    return p[47:16];
  endfunction

  // truncated 2^32 / v, zero divisor gives 0
  function automatic logic [DataW-1:0] fixrecip(input logic [DataW-1:0] v);
    logic signed [63:0] d, q;
    d = $signed(v);
    if (d == 0) return '0;
    q = 64'sh1_0000_0000 / d;
    return q[31:0];
  endfunction

  function automatic logic [DataW-1:0] clamp_to_w(input logic [DataW-1:0] c, w);
    logic [DataW-1:0] nw;
    nw = -w;
    if ($signed(c) < $signed(nw)) c = nw;
    if ($signed(c) > $signed(w)) c = w;
    return c;
  endfunction

  function automatic vtx_result_t project_vertex(input logic [DataW-1:0] cx, cy, cz, w);
    logic [DataW-1:0] x, y, z, hi, r, wx, wy, dep;
    vtx_result_t o;
    x = clamp_to_w(cx, w);
    y = clamp_to_w(cy, w);
    z = clamp_to_w(cz, w);
    hi = $signed(w) >>> 24;
    if (hi != '0 && hi != '1) begin
      r = fixrecip($signed(w) >>> 8);
      o.inv_w = r << 4;
      wx = fixmul(fixmul($signed(x) >>> 8, r), vp_regs[RegScaleX]) + vp_regs[RegOriginX];
      wy = fixmul(fixmul($signed(y) >>> 8, r), vp_regs[RegScaleY]) + vp_regs[RegOriginY];
      dep = fixmul($signed(z) >>> 8, fixmul(vp_regs[RegDepthF], r)) + vp_regs[RegDepthB];
    end else begin
      r = fixrecip(w);
      o.inv_w = r << 12;
      wx = fixmul(fixmul(x, r), vp_regs[RegScaleX]) + vp_regs[RegOriginX];
      wx = (wx + 32'h800) & ~32'hfff;
      wy = fixmul(fixmul(y, r), vp_regs[RegScaleY]) + vp_regs[RegOriginY];
      wy = (wy + 32'h800) & ~32'hfff;
      dep = fixmul(fixmul(z, r), vp_regs[RegDepthF]) + vp_regs[RegDepthB];
    end
    o.win_x = wx;
    o.win_y = wy;
    if ($signed(dep) < 0) o.win_depth = '0;
    else if ($signed(dep) > 32'sh0000ffff) o.win_depth = '1;
    else o.win_depth = dep[15:0];
    return o;
  endfunction

  // count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[clip_to_window_viewport_transform_top] ERROR");
      $finish;
    end
  end

  // check results first, then record accepted items
  always @(posedge clk_i) begin
    vtx_result_t exp_r, got;
    if (done_o) begin
      got = '{win_x_o, win_y_o, win_depth_o, inv_w_o};
      if (pending_vtx.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: %h", $time, got);
      end else begin
        exp_r = pending_vtx.pop_front();
        if (got.win_x !== exp_r.win_x) begin
          errors++;
          $display("%0t: win_x exp %h got %h", $time, exp_r.win_x, got.win_x);
        end
        if (got.win_y !== exp_r.win_y) begin
          errors++;
          $display("%0t: win_y exp %h got %h", $time, exp_r.win_y, got.win_y);
        end
        if (got.win_depth !== exp_r.win_depth) begin
          errors++;
          $display("%0t: win_depth exp %h got %h", $time, exp_r.win_depth, got.win_depth);
        end
        if (got.inv_w !== exp_r.inv_w) begin
          errors++;
          $display("%0t: inv_w exp %h got %h", $time, exp_r.inv_w, got.inv_w);
        end
      end
    end
    if (rst_ni && start && !busy) begin
      exp_r = project_vertex(clip_x_i, clip_y_i, clip_z_i, clip_w_i);
      if (typed_flag.size() != 0 && typed_flag.pop_front()) exp_r = typed_vtx.pop_front();
      pending_vtx.push_back(exp_r);
    end
  end

  // drive one item after a random gap and hold it until accepted
  task automatic send_vertex(input logic [DataW-1:0] x, y, z, w);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    clip_x_i <= x;
    clip_y_i <= y;
    clip_z_i <= z;
    clip_w_i <= w;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_vtx.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [DataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vp_regs[idx] = val;
  endtask

  task automatic load_viewport(input logic [DataW-1:0] sx, sy, ox, oy, df, db);
    wait_drained();
    write_reg(RegScaleX, sx);
    write_reg(RegScaleY, sy);
    write_reg(RegOriginX, ox);
    write_reg(RegOriginY, oy);
    write_reg(RegDepthF, df);
    write_reg(RegDepthB, db);
  endtask

  // random vertex, mostly well-formed with x, y, z near the -w..w box
  task automatic random_vertex();
    logic [DataW-1:0] w, x, y, z;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind) inside
      [0:3]: begin
        w = $urandom_range(32'h100, 32'h00ff_ffff);
        if ($urandom_range(0, 1)) w = -w;
      end
      [4:5]: begin
        w = $urandom();
        w[31:24] = $urandom_range(1, 254);
      end
      6: begin
        case ($urandom_range(0, 4))
          0: w = 32'h0;
          1: w = 32'h1;
          2: w = 32'hffff_ffff;
          3: w = 32'h8000_0000;
          default: w = 32'h7fff_ffff;
        endcase
      end
      default: w = $urandom();
    endcase
    if (kind < 7) begin
      x = $signed(w) >>> $urandom_range(0, 3);
      y = $signed(w) >>> $urandom_range(0, 3);
      z = $signed(w) >>> $urandom_range(0, 3);
      x = $urandom_range(0, 1) ? x ^ ($urandom() >> $urandom_range(8, 31)) : -x;
      y = $urandom_range(0, 1) ? y ^ ($urandom() >> $urandom_range(8, 31)) : -y;
      z = $urandom_range(0, 1) ? z ^ ($urandom() >> $urandom_range(8, 31)) : -z;
    end else begin
      x = $urandom();
      y = $urandom();
      z = $urandom();
    end
    send_vertex(x, y, z, w);
  endtask

  task automatic random_phase(input int unsigned n);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_vertex();
    end
    no_idle = 1'b0;
  endtask

  vtx_row_t dir_rows [] = '{
    // with reset registers everything collapses to 0 except inv_w
    '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0, 1'b1, '{0, 0, 0, 0}},
    '{32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h1, 1'b1, '{0, 0, 0, 0}},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 1'b1, '{0, 0, 0, 0}},
    '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h8000_0000, 1'b1,
      '{0, 0, 0, 32'hffff_e000}},
    '{32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b1, '{0, 0, 0, 32'h1000_0000}},
    '{32'h0, 32'h0, 32'h0, 32'hffff_0000, 1'b1, '{0, 0, 0, 32'hf000_0000}},
    // predicted rows
    '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0, '{0, 0, 0, 0}},
    '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000, 1'b0, '{0, 0, 0, 0}},
    '{32'h00ff_ffff, 32'hff00_0001, 32'h0080_0000, 32'h00ff_ffff, 1'b0, '{0, 0, 0, 0}},
    '{32'h0000_8000, 32'hffff_8000, 32'h0000_4000, 32'h0001_0000, 1'b0, '{0, 0, 0, 0}},
    '{32'h0000_0800, 32'h0000_07ff, 32'h0001_0000, 32'h0002_0000, 1'b0, '{0, 0, 0, 0}},
    '{32'hfff0_0000, 32'h0010_0000, 32'hfff0_0000, 32'hff00_0000, 1'b0, '{0, 0, 0, 0}},
    '{32'h1234_5678, 32'h9abc_def0, 32'h0fed_cba9, 32'hfeff_ffff, 1'b0, '{0, 0, 0, 0}},
    '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'h0, 1'b0, '{0, 0, 0, 0}},
    '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h1, 1'b0, '{0, 0, 0, 0}},
    '{32'h0000_0001, 32'hffff_ffff, 32'h0000_0002, 32'hffff_ffff, 1'b0, '{0, 0, 0, 0}},
    '{32'h4000_0000, 32'hc000_0000, 32'h2000_0000, 32'h8000_0000, 1'b0, '{0, 0, 0, 0}},
    '{32'h0000_3000, 32'h0000_c000, 32'hffff_c000, 32'h0000_c000, 1'b0, '{0, 0, 0, 0}}
  };

  initial begin
    foreach (vp_regs[i]) vp_regs[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // walk the directed table, first under reset registers
    for (int i = 0; i < 6; i++) begin
      typed_flag.push_back(dir_rows[i].typed);
      if (dir_rows[i].typed) typed_vtx.push_back(dir_rows[i].res);
      send_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].w);
    end
    load_viewport(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                  32'h7fff_ffff, 32'h8000_0000);
    for (int i = 6; i < dir_rows.size(); i++) send_vertex(dir_rows[i].x, dir_rows[i].y,
                                                          dir_rows[i].z, dir_rows[i].w);
    load_viewport(32'h0140_0000, 32'hff10_0000, 32'h0140_0000, 32'h00f0_0000,
                  32'h7fff_8000, 32'h0);
    for (int i = 6; i < dir_rows.size(); i++) send_vertex(dir_rows[i].x, dir_rows[i].y,
                                                          dir_rows[i].z, dir_rows[i].w);

    // random phases over several viewport settings
    random_phase(200);
    wait_drained();
    random_phase(100);
    load_viewport(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                  32'h8000_0000, 32'h7fff_ffff);
    random_phase(120);
    load_viewport(32'h0000_0000, 32'h0001_0000, 32'hffff_ffff, 32'h0000_8000,
                  32'h0000_ffff, 32'h0000_7fff);
    random_phase(120);
    load_viewport($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    random_phase(120);
    load_viewport(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0, 32'hffff_0000, 32'h0000_8000);
    random_phase(120);

    wait_drained();
    if (errors == 0) begin
      $display("[clip_to_window_viewport_transform_top] OK");
    end else begin
      $display("[clip_to_window_viewport_transform_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
sv/ctwvt_pkg.sv
sv/ctwvt_recip.sv
sv/clip_to_window_viewport_transform_top.sv
bench/tb_top.sv
